/* rtl/core/hsv_rgb_color_unit_defines.svh */
// ----------------------------------------------------------------------------
// hsv_rgb_color_unit assertion macros
// Shared property wrappers, clocked on clk with arst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef HSV_RGB_COLOR_UNIT_DEFINES_SVH
`define HSV_RGB_COLOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define HRC_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hsv_rgb_color_unit: same-cycle check failed");

// Next-cycle implication
`define HRC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hsv_rgb_color_unit: next-cycle check failed");

`endif

/* rtl/core/hrc_pkg.sv */
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants of the HSV/RGB color unit.
// ----------------------------------------------------------------------------
package hrc_pkg;

	// Operation codes
	localparam logic [1:0] KIND_HSV2RGB = 2'd0;
	localparam logic [1:0] KIND_RGB2HSV = 2'd1;
	localparam logic [1:0] KIND_ROTATE  = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	// Channel holding the maximum of an RGB pixel
	localparam logic [1:0] MAX_RED   = 2'd0;
	localparam logic [1:0] MAX_GREEN = 2'd1;
	localparam logic [1:0] MAX_BLUE  = 2'd2;

	localparam logic [7:0] HUE_SECTOR = 8'd43;
	localparam logic [7:0] HUE_GREEN  = 8'd85;
	localparam logic [7:0] HUE_BLUE   = 8'd171;
	localparam logic [7:0] CH_MAX     = 8'd255;
	localparam logic [2:0] SECTOR_SCALE = 3'd6;

	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} pix_t;

	// Sideband that rides along with every beat
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] off;
		pix_t       pix;
	} meta_t;

	// Raw RGB to HSV terms ahead of the hue assembly
	typedef struct packed {
		logic [7:0] mx;
		logic [7:0] d;
		logic [1:0] sel;
		logic       neg;
		logic [7:0] sat_q;
		logic [5:0] hue_q;
	} hsv_raw_t;

endpackage

/* rtl/core/hsv_rgb_color_unit.sv */
// Throughput: one pixel per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Depth is set by the eight-stage saturation/hue divider plus six stages of
// analysis, hue assembly, HSV to RGB products and the output register.
// Reset clears valid bits only.
// ----------------------------------------------------------------------------
// hsv_rgb_color_unit
// Streaming 8-bit HSV/RGB converter with hue rotate.
// ----------------------------------------------------------------------------
`include "hsv_rgb_color_unit_defines.svh"

module hsv_rgb_color_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] chan0,
	input  logic [7:0] chan1,
	input  logic [7:0] chan2,
	input  logic [7:0] hue_offset,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out0,
	output logic [7:0] out1,
	output logic [7:0] out2
);

	logic              en;
	hrc_pkg::meta_t    meta_in, meta_s9, meta_c13;
	hrc_pkg::hsv_raw_t raw_s9;
	logic              vld_s9, vld_c13;
	logic              vld_s10, vld_s14;
	hrc_pkg::pix_t     hsv_s10, rgb_c13, pix_s14;
	hrc_pkg::meta_t    meta_s10;
	logic [7:0]        base, hq, h, s, rot_h;
	hrc_pkg::pix_t     conv_in, keep_pix, result;

	assign en       = !vld_s14 || out_ready;
	assign in_ready = en;
	assign meta_in  = '{kind: kind, off: hue_offset, pix: '{c0: chan0, c1: chan1, c2: chan2}};

	hrc_rgb2hsv u_rgb2hsv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.meta_in   (meta_in),
		.out_valid (vld_s9),
		.raw       (raw_s9),
		.meta_out  (meta_s9)
	);

	// Assemble hue and saturation, apply rotation, pick converter input
	always_comb begin
		case (raw_s9.sel)
			hrc_pkg::MAX_RED:   base = 8'd0;
			hrc_pkg::MAX_GREEN: base = hrc_pkg::HUE_GREEN;
			default:            base = hrc_pkg::HUE_BLUE;
		endcase
		hq = {2'b00, raw_s9.hue_q};
		h  = raw_s9.neg ? base - hq : base + hq;
		s  = raw_s9.sat_q;
		if (raw_s9.mx == 8'd0) begin
			s = 8'd0;
		end
		if (raw_s9.d == 8'd0) begin
			h = 8'd0;
		end
		rot_h    = h + meta_s9.off;
		keep_pix = meta_s9.pix;
		if (meta_s9.kind == hrc_pkg::KIND_HSV2RGB) begin
			conv_in = meta_s9.pix;
		end else begin
			conv_in = '{c0: rot_h, c1: s, c2: raw_s9.mx};
		end
		if (meta_s9.kind == hrc_pkg::KIND_RGB2HSV) begin
			keep_pix = '{c0: h, c1: s, c2: raw_s9.mx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsv_s10  <= conv_in;
			meta_s10 <= '{kind: meta_s9.kind, off: meta_s9.off, pix: keep_pix};
		end
	end

	hrc_hsv2rgb u_hsv2rgb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s10),
		.hsv       (hsv_s10),
		.meta_in   (meta_s10),
		.out_valid (vld_c13),
		.rgb       (rgb_c13),
		.meta_out  (meta_c13)
	);

	// Choose the final pixel by operation
	always_comb begin
		case (meta_c13.kind)
			hrc_pkg::KIND_HSV2RGB: result = rgb_c13;
			hrc_pkg::KIND_RGB2HSV: result = meta_c13.pix;
			hrc_pkg::KIND_ROTATE:  result = (meta_c13.off == 8'd0) ? meta_c13.pix : rgb_c13;
			default:               result = '0;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s14 <= vld_c13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s14 <= result;
		end
	end

	assign out_valid = vld_s14;
	assign out0      = pix_s14.c0;
	assign out1      = pix_s14.c1;
	assign out2      = pix_s14.c2;

	// Spread never exceeds the maximum channel
	`HRC_ASSERT_IMPLY(a_spread_le_max, vld_s9, raw_s9.d <= raw_s9.mx)
	// Hue quotient stays within one sector
	`HRC_ASSERT_IMPLY(a_hue_q_range, vld_s9 && raw_s9.d != 8'd0, raw_s9.hue_q <= 6'd43)
	// A stall freezes the middle of the pipe
	`HRC_ASSERT_NEXT(a_stall_holds, !en && arst_n, $stable(vld_s10) && $stable(hsv_s10))

endmodule

/* rtl/core/hrc_rgb2hsv.sv */
// ----------------------------------------------------------------------------
// hrc_rgb2hsv
// Max/min analysis followed by two bit-per-stage restoring dividers
// (saturation and hue) in lockstep over eight stages.
// ----------------------------------------------------------------------------
module hrc_rgb2hsv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  hrc_pkg::meta_t   meta_in,
	output logic             out_valid,
	output hrc_pkg::hsv_raw_t raw,
	output hrc_pkg::meta_t   meta_out
);

	typedef struct packed {
		hrc_pkg::meta_t    meta;
		hrc_pkg::hsv_raw_t raw;
		logic [15:0]       sat_rem;
		logic [13:0]       hue_rem;
	} div_t;

	// Resolve one quotient bit of each divider
	function automatic div_t div_step(input div_t a, input int unsigned i);
		div_t        o;
		logic [15:0] sden;
		logic [13:0] hden;
		o    = a;
		sden = 16'(a.raw.mx) << i;
		hden = 14'(a.raw.d) << i;
		if (a.sat_rem >= sden) begin
			o.sat_rem   = a.sat_rem - sden;
			o.raw.sat_q = a.raw.sat_q | (8'd1 << i);
		end
		if (i < 6 && a.hue_rem >= hden) begin
			o.hue_rem   = a.hue_rem - hden;
			o.raw.hue_q = a.raw.hue_q | (6'd1 << i);
		end
		return o;
	endfunction

	div_t       div_s [0:8];
	logic [8:0] vld_s;
	div_t       first;
	logic [7:0] r, g, b, mx, mn, d, mag;
	logic [8:0] diff;
	logic [1:0] sel;

	// Find max, min and the signed hue difference
	always_comb begin
		r = meta_in.pix.c0;
		g = meta_in.pix.c1;
		b = meta_in.pix.c2;
		if (r >= g && r >= b) begin
			mx   = r;
			sel  = hrc_pkg::MAX_RED;
			diff = {1'b0, g} - {1'b0, b};
		end else if (g >= b) begin
			mx   = g;
			sel  = hrc_pkg::MAX_GREEN;
			diff = {1'b0, b} - {1'b0, r};
		end else begin
			mx   = b;
			sel  = hrc_pkg::MAX_BLUE;
			diff = {1'b0, r} - {1'b0, g};
		end
		mn  = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
		d   = mx - mn;
		mag = diff[8] ? 8'(-diff) : diff[7:0];
		first.meta      = meta_in;
		first.raw.mx    = mx;
		first.raw.d     = d;
		first.raw.sel   = sel;
		first.raw.neg   = diff[8];
		first.raw.sat_q = '0;
		first.raw.hue_q = '0;
		first.sat_rem   = {d, 8'd0} - {8'd0, d};
		first.hue_rem   = 14'({6'd0, mag} * 14'(hrc_pkg::HUE_SECTOR));
	end

	// Capture the analysis stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= first;
		end
	end

	// Advance one quotient bit per stage, most significant first
	for (genvar k = 0; k < 8; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_step(div_s[k], 7 - k);
			end
		end
	end

	assign out_valid = vld_s[8];
	assign raw       = div_s[8].raw;
	assign meta_out  = div_s[8].meta;

endmodule

/* rtl/core/hrc_hsv2rgb.sv */
// ----------------------------------------------------------------------------
// hrc_hsv2rgb
// Three-stage HSV to RGB: sector split, first products, scaled products,
// then sector routing of v, p, q and t.
// ----------------------------------------------------------------------------
module hrc_hsv2rgb (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  hrc_pkg::pix_t  hsv,
	input  hrc_pkg::meta_t meta_in,
	output logic           out_valid,
	output hrc_pkg::pix_t  rgb,
	output hrc_pkg::meta_t meta_out
);

	localparam logic [2:0] SECT_RED     = 3'd0;
	localparam logic [2:0] SECT_YELLOW  = 3'd1;
	localparam logic [2:0] SECT_GREEN   = 3'd2;
	localparam logic [2:0] SECT_CYAN    = 3'd3;
	localparam logic [2:0] SECT_BLUE    = 3'd4;
	localparam logic [2:0] SECT_MAGENTA = 3'd5;

	logic [7:0]  h, sect_base, rem;
	logic [2:0]  sect;
	logic [10:0] rem_full;

	logic           vld_s11, vld_s12, vld_s13;
	logic [2:0]     sect_s11, sect_s12, sect_s13;
	logic [7:0]     rem_s11, s_s11, v_s11, v_s12, v_s13;
	logic           szero_s12, szero_s13;
	logic [15:0]    sr_s12, srn_s12, vp_s12;
	logic [7:0]     p_s13, q_s13, t_s13;
	hrc_pkg::meta_t meta_s11, meta_s12, meta_s13;
	logic [15:0]    q_prod, t_prod;

	// Split hue into a sector and a scaled remainder
	always_comb begin
		h = hsv.c0;
		if (h >= 8'd215) begin
			sect = SECT_MAGENTA;
		end else if (h >= 8'd172) begin
			sect = SECT_BLUE;
		end else if (h >= 8'd129) begin
			sect = SECT_CYAN;
		end else if (h >= 8'd86) begin
			sect = SECT_GREEN;
		end else if (h >= hrc_pkg::HUE_SECTOR) begin
			sect = SECT_YELLOW;
		end else begin
			sect = SECT_RED;
		end
		sect_base = 8'(sect * hrc_pkg::HUE_SECTOR);
		rem_full  = 11'(h - sect_base) * 11'(hrc_pkg::SECTOR_SCALE);
		rem       = rem_full[7:0];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s11 <= in_valid;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// Scaled products: q and t need the saturation terms first
	assign q_prod = {8'd0, v_s12} * {8'd0, hrc_pkg::CH_MAX - sr_s12[15:8]};
	assign t_prod = {8'd0, v_s12} * {8'd0, hrc_pkg::CH_MAX - srn_s12[15:8]};

	always_ff @(posedge clk) begin
		if (en) begin
			sect_s11  <= sect;
			rem_s11   <= rem;
			s_s11     <= hsv.c1;
			v_s11     <= hsv.c2;
			meta_s11  <= meta_in;

			sect_s12  <= sect_s11;
			v_s12     <= v_s11;
			szero_s12 <= (s_s11 == 8'd0);
			sr_s12    <= {8'd0, s_s11} * {8'd0, rem_s11};
			srn_s12   <= {8'd0, s_s11} * {8'd0, hrc_pkg::CH_MAX - rem_s11};
			vp_s12    <= {8'd0, v_s11} * {8'd0, hrc_pkg::CH_MAX - s_s11};
			meta_s12  <= meta_s11;

			sect_s13  <= sect_s12;
			v_s13     <= v_s12;
			szero_s13 <= szero_s12;
			p_s13     <= vp_s12[15:8];
			q_s13     <= q_prod[15:8];
			t_s13     <= t_prod[15:8];
			meta_s13  <= meta_s12;
		end
	end

	// Route v, p, q, t by sector; grey when unsaturated
	always_comb begin
		if (szero_s13) begin
			rgb = '{c0: v_s13, c1: v_s13, c2: v_s13};
		end else begin
			case (sect_s13)
				SECT_RED:    rgb = '{c0: v_s13, c1: t_s13, c2: p_s13};
				SECT_YELLOW: rgb = '{c0: q_s13, c1: v_s13, c2: p_s13};
				SECT_GREEN:  rgb = '{c0: p_s13, c1: v_s13, c2: t_s13};
				SECT_CYAN:   rgb = '{c0: p_s13, c1: q_s13, c2: v_s13};
				SECT_BLUE:   rgb = '{c0: t_s13, c1: p_s13, c2: v_s13};
				default:     rgb = '{c0: v_s13, c1: p_s13, c2: q_s13};
			endcase
		end
	end

	assign out_valid = vld_s13;
	assign meta_out  = meta_s13;

endmodule

/* tb/hsv_rgb_color_checker.sv */
// ----------------------------------------------------------------------------
// hsv_rgb_color_checker
// Watches both channels of the color unit, predicts each pixel result from
// the accepted input beat and compares it field by field in order.
// ----------------------------------------------------------------------------
module hsv_rgb_color_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] chan0,
	input  logic [7:0] chan1,
	input  logic [7:0] chan2,
	input  logic [7:0] hue_offset,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out0,
	input  logic [7:0] out1,
	input  logic [7:0] out2,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	hrc_pkg::pix_t pix_expected_q[$];

	// HSV to RGB with six hue regions
	function automatic hrc_pkg::pix_t hsv_pix_to_rgb(logic [7:0] h, logic [7:0] s,
			logic [7:0] v);
		hrc_pkg::pix_t o;
		int unsigned region, rem, p, q, t;
		if (s == 0) begin
			o = '{v, v, v};
			return o;
		end
		region = h / 43;
		rem = ((h - region * 43) * 6) & 8'hFF;
		p = ((v * (255 - s)) >> 8) & 8'hFF;
		q = ((v * (255 - ((s * rem) >> 8))) >> 8) & 8'hFF;
		t = ((v * (255 - ((s * (255 - rem)) >> 8))) >> 8) & 8'hFF;
		case (region)
			0: o = '{v, t[7:0], p[7:0]};
			1: o = '{q[7:0], v, p[7:0]};
			2: o = '{p[7:0], v, t[7:0]};
			3: o = '{p[7:0], q[7:0], v};
			4: o = '{t[7:0], p[7:0], v};
			default: o = '{v, p[7:0], q[7:0]};
		endcase
		return o;
	endfunction

	// RGB to HSV; SV signed division already truncates toward zero
	function automatic hrc_pkg::pix_t rgb_pix_to_hsv(logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		hrc_pkg::pix_t o;
		int ri, gi, bi, mx, mn, d, h;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = (ri > gi) ? ((ri > bi) ? ri : bi) : ((gi > bi) ? gi : bi);
		mn = (ri < gi) ? ((ri < bi) ? ri : bi) : ((gi < bi) ? gi : bi);
		o = '0;
		o.c2 = mx[7:0];
		if (mx == 0)
			return o;
		d = mx - mn;
		o.c1 = 8'((255 * d) / mx);
		if (d == 0)
			return o;
		if (mx == ri)
			h = (43 * (gi - bi)) / d;
		else if (mx == gi)
			h = 85 + (43 * (bi - ri)) / d;
		else
			h = 171 + (43 * (ri - gi)) / d;
		o.c0 = h[7:0];
		return o;
	endfunction

	function automatic hrc_pkg::pix_t color_result(logic [1:0] k, hrc_pkg::pix_t px,
			logic [7:0] off);
		hrc_pkg::pix_t hsv;
		case (k)
			hrc_pkg::KIND_HSV2RGB: return hsv_pix_to_rgb(px.c0, px.c1, px.c2);
			hrc_pkg::KIND_RGB2HSV: return rgb_pix_to_hsv(px.c0, px.c1, px.c2);
			hrc_pkg::KIND_ROTATE: begin
				if (off == 0)
					return px;
				hsv = rgb_pix_to_hsv(px.c0, px.c1, px.c2);
				return hsv_pix_to_rgb(hsv.c0 + off, hsv.c1, hsv.c2);
			end
			default: return '0;
		endcase
	endfunction

	// Predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		hrc_pkg::pix_t exp_pix;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				pix_expected_q.push_back(color_result(kind, '{chan0, chan1, chan2},
					hue_offset));
			if (out_valid && out_ready) begin
				if (pix_expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %h %h %h", out0, out1, out2);
					fail_count <= fail_count + 1;
				end else begin
					exp_pix = pix_expected_q.pop_front();
					if (exp_pix != hrc_pkg::pix_t'({out0, out1, out2})) begin
						if (fail_count < 10)
							$display("mismatch: expected %h %h %h, got %h %h %h",
								exp_pix.c0, exp_pix.c1, exp_pix.c2, out0, out1, out2);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		pending = pix_expected_q.size();
	end
endmodule

/* tb/tb_hsv_rgb_color_unit.sv */
// ----------------------------------------------------------------------------
// tb_hsv_rgb_color_unit
// Streams directed and random pixels of every kind through the color unit
// with bursty input, a patterned output stall and one long backpressure hold.
// ----------------------------------------------------------------------------
module tb_hsv_rgb_color_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = hrc_pkg::KIND_HSV2RGB;
	logic [7:0] chan0 = '0, chan1 = '0, chan2 = '0, hue_offset = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out0, out1, out2;
	int         fail_count, pending;
	bit         hold_off = 1'b0;

	hsv_rgb_color_unit dut (.*);
	hsv_rgb_color_checker chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one beat and hold it until accepted
	task automatic send_pixel(logic [1:0] k, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
			logic [7:0] off);
		in_valid <= 1'b1;
		kind <= k;
		chan0 <= c0;
		chan1 <= c1;
		chan2 <= c2;
		hue_offset <= off;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random;
		logic [1:0] k;
		logic [7:0] c0, c1, c2, off;
		int mode;
		k = 2'($urandom_range(2, 0));
		if ($urandom_range(40, 0) == 0)
			k = hrc_pkg::KIND_UNUSED;
		c0 = 8'($urandom);
		c1 = 8'($urandom);
		c2 = 8'($urandom);
		off = 8'($urandom);
		mode = $urandom_range(9, 0);
		// push toward grey, zero offset and equal-maximum ties
		if (mode == 0) begin
			c1 = c0;
			c2 = c0;
		end else if (mode == 1) begin
			c1 = c0;
		end else if (mode == 2) begin
			c2 = c1;
		end else if (mode == 3) begin
			off = '0;
		end
		send_pixel(k, c0, c1, c2, off);
	endtask

	// Receiver stall pattern, with stretches of none
	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else if (($time / 400) % 3 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(3, 0) != 0);
	end

	initial begin
		#200000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int burst;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, every operation, special cases
		send_pixel(hrc_pkg::KIND_HSV2RGB, 8'd0, 8'd0, 8'd255, 8'd0);
		send_pixel(hrc_pkg::KIND_HSV2RGB, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(hrc_pkg::KIND_HSV2RGB, 8'd42, 8'd255, 8'd200, 8'd0);
		send_pixel(hrc_pkg::KIND_HSV2RGB, 8'd43, 8'd128, 8'd255, 8'd0);
		send_pixel(hrc_pkg::KIND_HSV2RGB, 8'd128, 8'd1, 8'd1, 8'd0);
		send_pixel(hrc_pkg::KIND_HSV2RGB, 8'd215, 8'd255, 8'd0, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd77, 8'd77, 8'd77, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd255, 8'd0, 8'd255, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd255, 8'd0, 8'd1, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd0, 8'd255, 8'd0, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd0, 8'd0, 8'd255, 8'd0);
		send_pixel(hrc_pkg::KIND_RGB2HSV, 8'd1, 8'd255, 8'd255, 8'd0);
		send_pixel(hrc_pkg::KIND_ROTATE, 8'd12, 8'd200, 8'd99, 8'd0);
		send_pixel(hrc_pkg::KIND_ROTATE, 8'd255, 8'd0, 8'd0, 8'd255);
		send_pixel(hrc_pkg::KIND_ROTATE, 8'd0, 8'd0, 8'd0, 8'd128);
		send_pixel(hrc_pkg::KIND_ROTATE, 8'd90, 8'd90, 8'd90, 8'd1);
		send_pixel(hrc_pkg::KIND_ROTATE, 8'd10, 8'd250, 8'd130, 8'd85);
		send_pixel(hrc_pkg::KIND_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);

		// Long output hold while input keeps being offered
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (40) send_random();
		join

		// Random bursts with gaps
		for (int n = 0; n < 560; n += burst) begin
			burst = $urandom_range(20, 1);
			repeat (burst) send_random();
			if ($urandom_range(2, 0) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(negedge clk);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hrc_pkg.sv
rtl/core/hrc_rgb2hsv.sv
rtl/core/hrc_hsv2rgb.sv
rtl/core/hsv_rgb_color_unit.sv
tb/hsv_rgb_color_checker.sv
tb/tb_hsv_rgb_color_unit.sv
